// ===== hdl/smv_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smv_pkg
// Shared types, constants and saturating add for the sparse matrix-vector multiply unit.
// ----------------------------------------------------------------------------
package smv_pkg;

	// vector store geometry and value format
	localparam int VECTOR_DEPTH = 4096;
	localparam int VALUE_WIDTH  = 32;
	localparam int ADDR_W       = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
	localparam int PROD_W       = 2 * VALUE_WIDTH;

	// fixed field widths
	localparam int REQ_W   = 2;
	localparam int IDX_W   = 12;
	localparam int IN_W    = 32;
	localparam int ACC_W   = 64;
	localparam int LINE_W  = 12;
	localparam int DIM_W   = 13;
	localparam int CFG_I_W = 2;

	// request codes
	localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_ENTRY = 2'd1;
	localparam logic [REQ_W-1:0] REQ_EMPTY = 2'd2;

	// configuration register indexes
	localparam logic [CFG_I_W-1:0] CFG_NUM_ROWS  = 2'd0;
	localparam logic [CFG_I_W-1:0] CFG_NUM_COLS  = 2'd1;
	localparam logic [CFG_I_W-1:0] CFG_TRANSPOSE = 2'd2;

	// operation carried down the pipeline
	typedef enum logic [1:0] {
		OP_NOP,
		OP_ENTRY,
		OP_CLOSE
	} op_t;

	typedef struct packed {
		logic valid;
		op_t  op;
		logic in_range;
		logic last;
	} pipe_ctl_t;

	// saturating signed add on the accumulator width
	function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
		input logic [ACC_W-1:0] b);
		logic [ACC_W:0] s;
		s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
		if (s[ACC_W] != s[ACC_W-1]) begin
			return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end
		return s[ACC_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== hdl/smv_vec_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smv_vec_store
// Single-port-write, single-port-read vector memory, registered read data.
// ----------------------------------------------------------------------------
module smv_vec_store (
	input  wire logic                           clk,
	input  wire logic                           wr_en,
	input  wire logic [smv_pkg::ADDR_W-1:0]      wr_addr,
	input  wire logic [smv_pkg::VALUE_WIDTH-1:0] wr_data,
	input  wire logic                           rd_en,
	input  wire logic [smv_pkg::ADDR_W-1:0]      rd_addr,
	output      logic [smv_pkg::VALUE_WIDTH-1:0] rd_data
);

	logic [smv_pkg::VALUE_WIDTH-1:0] mem [smv_pkg::VECTOR_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read held while the pipeline is stalled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== hdl/smv_mac.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smv_mac
// Multiply stage, saturating line accumulator and result register.
// ----------------------------------------------------------------------------
module smv_mac (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            adv,
	input  wire smv_pkg::pipe_ctl_t              ctl_s1,
	input  wire logic [smv_pkg::VALUE_WIDTH-1:0] val_s1,
	input  wire logic [smv_pkg::VALUE_WIDTH-1:0] vec_s1,
	output      logic                            blocked,
	output      logic                            out_valid,
	input  wire logic                            out_ready,
	output      logic [smv_pkg::ACC_W-1:0]       line_sum,
	output      logic [smv_pkg::LINE_W-1:0]      line_number,
	output      logic                            index_error
);

	smv_pkg::pipe_ctl_t             ctl_s2;
	logic [smv_pkg::ACC_W-1:0]      prod_s2;
	logic [smv_pkg::ACC_W-1:0]      acc_q;
	logic                           err_q;
	logic [smv_pkg::LINE_W-1:0]     cnt_q;
	logic                           out_valid_q;
	logic [smv_pkg::ACC_W-1:0]      sum_q;
	logic [smv_pkg::LINE_W-1:0]     num_q;
	logic                           oerr_q;

	logic                           is_entry;
	logic                           ends;
	logic                           fire;
	logic [smv_pkg::ACC_W-1:0]      acc_nxt;
	logic                           err_nxt;
	logic signed [smv_pkg::PROD_W-1:0] prod;

	assign prod = $signed(val_s1) * $signed(vec_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (adv) begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2 <= smv_pkg::ACC_W'(prod);
		end
	end

	always_comb begin
		is_entry = (ctl_s2.op == smv_pkg::OP_ENTRY);
		ends     = (is_entry && ctl_s2.last) || (ctl_s2.op == smv_pkg::OP_CLOSE);
		blocked  = ctl_s2.valid && ends && out_valid_q && !out_ready;
		fire     = ctl_s2.valid && adv;
		acc_nxt  = (is_entry && ctl_s2.in_range) ? smv_pkg::sat_add(acc_q, prod_s2) : acc_q;
		err_nxt  = err_q || (is_entry && !ctl_s2.in_range);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			err_q       <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (fire && ends) begin
				acc_q       <= '0;
				err_q       <= 1'b0;
				cnt_q       <= cnt_q + 1'b1;
				out_valid_q <= 1'b1;
			end else if (fire && is_entry) begin
				acc_q <= acc_nxt;
				err_q <= err_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && ends) begin
			sum_q  <= acc_nxt;
			num_q  <= cnt_q;
			oerr_q <= err_nxt;
		end
	end

	assign out_valid   = out_valid_q;
	assign line_sum    = sum_q;
	assign line_number = num_q;
	assign index_error = oerr_q;

endmodule
`default_nettype wire

// ===== hdl/sparse_matrix_vector_multiply_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sparse_matrix_vector_multiply_unit
// Sparse matrix (one line at a time) times a dense Q16.16 vector.
// ----------------------------------------------------------------------------
// Usage:
//   Configure num_rows, num_cols and transpose_mode on the cfg channel while
//   idle (cfg_ready is always high). Load vector elements with request type
//   "load", then stream each line's nonzero entries with line_last on the
//   final one, or send one "empty line" request for a line with no entries.
//   Each finished line yields one request on the out channel: the saturating
//   Q32.32 dot product, the line number and an index error flag.
// Pipeline: a closing request's store read happens at the edge that accepts
//   it, then the product is registered, then the accumulate/result register
//   raises out_valid.
// Throughput: one request per cycle unless stalled, loads and entries alike; the
//   store has one write and one read port and a load is visible to the next request.
// Stall: the result register holds while out_ready is low; requests keep
//   flowing until a second line end reaches the accumulator, then in_ready
//   drops until the held result is taken.
// Reset: arst_n clears the pipeline, accumulator, line counter and
//   configuration. The vector store is not cleared.
// ----------------------------------------------------------------------------
module sparse_matrix_vector_multiply_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output      logic                              in_ready,
	input  wire logic [smv_pkg::REQ_W-1:0]         req_type,
	input  wire logic [smv_pkg::IDX_W-1:0]         entry_index,
	input  wire logic signed [smv_pkg::IN_W-1:0]   entry_value,
	input  wire logic                              line_last,
	output      logic                              out_valid,
	input  wire logic                              out_ready,
	output      logic signed [smv_pkg::ACC_W-1:0]  line_sum,
	output      logic [smv_pkg::LINE_W-1:0]        line_number,
	output      logic                              index_error,
	input  wire logic                              cfg_valid,
	output      logic                              cfg_ready,
	input  wire logic [smv_pkg::CFG_I_W-1:0]       cfg_index,
	input  wire logic [smv_pkg::DIM_W-1:0]         cfg_data
);

	logic [smv_pkg::DIM_W-1:0]        num_rows_q;
	logic [smv_pkg::DIM_W-1:0]        num_cols_q;
	logic                             transpose_q;

	logic                             adv;
	logic                             blocked;
	logic                             acc_in;
	logic [smv_pkg::DIM_W-1:0]        limit;
	logic                             depth_ok;
	logic [smv_pkg::ADDR_W-1:0]       addr;
	logic [smv_pkg::VALUE_WIDTH-1:0]  val_in;
	smv_pkg::pipe_ctl_t               ctl_in;
	smv_pkg::pipe_ctl_t               ctl_s1;
	logic [smv_pkg::VALUE_WIDTH-1:0]  val_s1;
	logic [smv_pkg::VALUE_WIDTH-1:0]  vec_s1;
	logic [smv_pkg::ACC_W-1:0]        sum_w;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q  <= '0;
			num_cols_q  <= '0;
			transpose_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				smv_pkg::CFG_NUM_ROWS:  num_rows_q  <= cfg_data;
				smv_pkg::CFG_NUM_COLS:  num_cols_q  <= cfg_data;
				smv_pkg::CFG_TRANSPOSE: transpose_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign adv      = !blocked;
	assign in_ready = adv;
	assign acc_in   = in_valid && adv;

	always_comb begin
		limit    = transpose_q ? num_rows_q : num_cols_q;
		depth_ok = (32'(entry_index) < 32'(smv_pkg::VECTOR_DEPTH));
		addr     = smv_pkg::ADDR_W'(entry_index);
		val_in   = entry_value[smv_pkg::VALUE_WIDTH-1:0];
		ctl_in.valid    = acc_in;
		ctl_in.in_range = ({1'b0, entry_index} < limit) && depth_ok;
		ctl_in.last     = line_last;
		case (req_type)
			smv_pkg::REQ_ENTRY: ctl_in.op = smv_pkg::OP_ENTRY;
			smv_pkg::REQ_EMPTY: ctl_in.op = smv_pkg::OP_CLOSE;
			default:            ctl_in.op = smv_pkg::OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			val_s1 <= val_in;
		end
	end

	smv_vec_store u_store (
		.clk     (clk),
		.wr_en   (acc_in && (req_type == smv_pkg::REQ_LOAD) && depth_ok),
		.wr_addr (addr),
		.wr_data (val_in),
		.rd_en   (adv),
		.rd_addr (addr),
		.rd_data (vec_s1)
	);

	smv_mac u_mac (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.ctl_s1      (ctl_s1),
		.val_s1      (val_s1),
		.vec_s1      (vec_s1),
		.blocked     (blocked),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.line_sum    (sum_w),
		.line_number (line_number),
		.index_error (index_error)
	);

	assign line_sum = sum_w;

endmodule
`default_nettype wire

// ===== hdl/smv_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smv_checker
// Port-level checks for the sparse matrix-vector multiply unit.
// ----------------------------------------------------------------------------
module smv_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         in_ready,
	input wire logic                         out_valid,
	input wire logic                         out_ready,
	input wire logic [smv_pkg::ACC_W-1:0]    line_sum,
	input wire logic [smv_pkg::LINE_W-1:0]   line_number,
	input wire logic                         index_error,
	input wire logic                         cfg_valid,
	input wire logic                         cfg_ready
);

	// a held result does not change
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(line_sum)
			&& $stable(line_number) && $stable(index_error))
		else $error("result changed while stalled");

	// back-to-back results belong to consecutive lines
	a_line_seq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready ##1 out_valid |->
			line_number == $past(line_number) + 12'd1)
		else $error("line number not consecutive");

	// input only stalls while a result is held
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind sparse_matrix_vector_multiply_unit smv_checker u_smv_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.line_sum    (line_sum),
	.line_number (line_number),
	.index_error (index_error),
	.cfg_valid   (cfg_valid),
	.cfg_ready   (cfg_ready)
);
`default_nettype wire
